@@ hdl/i6ap_pkg.sv @@
// shared types, constants and a helper function for the ipv6 text address parser
// no dependencies; used by i6ap_parse, i6ap_expand and ipv6_text_address_parser
`default_nettype none

package i6ap_pkg;

  localparam int NumGroups = 8;
  localparam int GroupW    = 16;
  localparam int AddrW     = NumGroups * GroupW;

  localparam logic [3:0] MaxGroups = 4'd8;
  localparam logic [2:0] MaxDigits = 3'd4;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] HexTen  = 8'd10;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_START_COLON = 3'd1,
    PH_GROUP_START = 3'd2,
    PH_IN_GROUP    = 3'd3,
    PH_AFTER_COLON = 3'd4
  } phase_e;

  // string summary at the terminating nul, group store already closed
  typedef struct packed {
    logic       err;
    logic       zrs;
    logic [3:0] zpos;
    logic [3:0] cnt;
  } fin_t;

  // {hit, value} of a hex digit, either case
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    logic       hit;
    v   = 8'd0;
    hit = 1'b0;
    if (c >= ChZero && c <= ChNine) begin
      v   = c - ChZero;
      hit = 1'b1;
    end else if (c >= ChLowA && c <= ChLowF) begin
      v   = c - ChLowA + HexTen;
      hit = 1'b1;
    end else if (c >= ChUpA && c <= ChUpF) begin
      v   = c - ChUpA + HexTen;
      hit = 1'b1;
    end
    return {hit, v[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ hdl/i6ap_parse.sv @@
// per-character parse state machine and group store
// depends on i6ap_pkg
`default_nettype none

module i6ap_parse (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         step_i,
  input  wire logic [7:0]                                   char_i,
  output i6ap_pkg::fin_t                                    fin_o,
  output logic [i6ap_pkg::NumGroups-1:0][i6ap_pkg::GroupW-1:0] groups_o
);

  i6ap_pkg::phase_e phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  zpos_q, zpos_d;
  logic        zrs_q, zrs_d;
  logic [2:0]  dig_q, dig_d;
  logic [15:0] val_q, val_d;
  logic        err_q, err_d;

  logic [i6ap_pkg::NumGroups-1:0][i6ap_pkg::GroupW-1:0] store_q;
  logic        store_we;
  logic [2:0]  store_waddr;

  logic [4:0]  nib;
  logic        is_colon;
  logic        do_open;
  logic        do_close;
  logic        cnt_full;
  logic        fin_close;

  always_comb begin
    nib         = i6ap_pkg::nibble_of(char_i);
    is_colon    = (char_i == i6ap_pkg::ChColon);
    cnt_full    = (cnt_q >= i6ap_pkg::MaxGroups);
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    zpos_d      = zpos_q;
    zrs_d       = zrs_q;
    dig_d       = dig_q;
    val_d       = val_q;
    err_d       = err_q;
    store_we    = 1'b0;
    store_waddr = cnt_q[2:0];
    do_open     = 1'b0;
    do_close    = 1'b0;

    if (char_i == i6ap_pkg::ChNul) begin
      phase_d = i6ap_pkg::PH_START;
      cnt_d   = 4'd0;
      zpos_d  = 4'd0;
      zrs_d   = 1'b0;
      dig_d   = 3'd0;
      val_d   = 16'd0;
      err_d   = 1'b0;
    end else if (!err_q) begin
      unique case (phase_q)
        i6ap_pkg::PH_START: begin
          if (is_colon) begin
            phase_d = i6ap_pkg::PH_START_COLON;
          end else begin
            do_open = 1'b1;
          end
        end
        i6ap_pkg::PH_START_COLON: begin
          if (is_colon) begin
            zrs_d   = 1'b1;
            zpos_d  = 4'd0;
            phase_d = i6ap_pkg::PH_GROUP_START;
          end else begin
            err_d = 1'b1;
          end
        end
        i6ap_pkg::PH_GROUP_START: begin
          do_open = 1'b1;
        end
        i6ap_pkg::PH_IN_GROUP: begin
          if (nib[4]) begin
            if (dig_q >= i6ap_pkg::MaxDigits) begin
              err_d = 1'b1;
            end else begin
              val_d = {val_q[11:0], nib[3:0]};
              dig_d = dig_q + 3'd1;
            end
          end else if (is_colon) begin
            do_close = 1'b1;
            phase_d  = i6ap_pkg::PH_AFTER_COLON;
          end else begin
            err_d = 1'b1;
          end
        end
        i6ap_pkg::PH_AFTER_COLON: begin
          if (is_colon) begin
            if (zrs_q) begin
              err_d = 1'b1;
            end else begin
              zrs_d   = 1'b1;
              zpos_d  = cnt_q;
              phase_d = i6ap_pkg::PH_GROUP_START;
            end
          end else begin
            do_open = 1'b1;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase

      if (do_open) begin
        if (cnt_full || !nib[4]) begin
          err_d = 1'b1;
        end else begin
          val_d   = {12'd0, nib[3:0]};
          dig_d   = 3'd1;
          phase_d = i6ap_pkg::PH_IN_GROUP;
        end
      end

      if (do_close) begin
        if (cnt_full) begin
          err_d = 1'b1;
        end else begin
          store_we = 1'b1;
          cnt_d    = cnt_q + 4'd1;
          dig_d    = 3'd0;
          val_d    = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i6ap_pkg::PH_START;
      cnt_q   <= 4'd0;
      zpos_q  <= 4'd0;
      zrs_q   <= 1'b0;
      dig_q   <= 3'd0;
      val_q   <= 16'd0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      zpos_q  <= zpos_d;
      zrs_q   <= zrs_d;
      dig_q   <= dig_d;
      val_q   <= val_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && store_we) begin
      store_q[store_waddr] <= val_q;
    end
  end

  // summary as it stands once the open group is closed by the nul
  always_comb begin
    fin_close = !err_q && (phase_q == i6ap_pkg::PH_IN_GROUP) && !cnt_full;
    fin_o.err = err_q || (phase_q == i6ap_pkg::PH_START_COLON)
             || ((phase_q == i6ap_pkg::PH_IN_GROUP) && cnt_full);
    fin_o.zrs  = zrs_q;
    fin_o.zpos = zpos_q;
    fin_o.cnt  = cnt_q + {3'd0, fin_close};
    for (int i = 0; i < i6ap_pkg::NumGroups; i++) begin
      if (fin_close && (cnt_q[2:0] == 3'(i))) begin
        groups_o[i] = val_q;
      end else begin
        groups_o[i] = store_q[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/i6ap_expand.sv @@
// zero-run expansion of the collected groups into the 128-bit address
// depends on i6ap_pkg
`default_nettype none

module i6ap_expand (
  input  wire i6ap_pkg::fin_t                               fin_i,
  input  wire logic [i6ap_pkg::NumGroups-1:0][i6ap_pkg::GroupW-1:0] groups_i,
  output logic                                              ok_o,
  output logic [63:0]                                       addr_high_o,
  output logic [63:0]                                       addr_low_o
);

  logic [3:0]                  fill;
  logic [4:0]                  run_end;
  logic [i6ap_pkg::AddrW-1:0]  flat;
  logic [i6ap_pkg::AddrW-1:0]  shifted;
  logic [i6ap_pkg::AddrW-1:0]  addr;
  logic [7:0]                  shamt;
  logic [4:0]                  idx;

  always_comb begin
    ok_o    = !fin_i.err && (fin_i.zrs || (fin_i.cnt == i6ap_pkg::MaxGroups));
    fill    = i6ap_pkg::MaxGroups - fin_i.cnt;
    run_end = {1'b0, fin_i.zpos} + {1'b0, fill};
    // group 0 sits in the top lane
    for (int i = 0; i < i6ap_pkg::NumGroups; i++) begin
      flat[i6ap_pkg::AddrW-1-i*i6ap_pkg::GroupW -: i6ap_pkg::GroupW] = groups_i[i];
    end
    // tail groups slide down by the run length
    shamt   = {fill, 4'd0};
    shifted = flat >> shamt;
    for (int i = 0; i < i6ap_pkg::NumGroups; i++) begin
      idx = 5'(i);
      if (!fin_i.zrs || (idx < {1'b0, fin_i.zpos})) begin
        addr[i6ap_pkg::AddrW-1-i*i6ap_pkg::GroupW -: i6ap_pkg::GroupW] =
          flat[i6ap_pkg::AddrW-1-i*i6ap_pkg::GroupW -: i6ap_pkg::GroupW];
      end else if (idx < run_end) begin
        addr[i6ap_pkg::AddrW-1-i*i6ap_pkg::GroupW -: i6ap_pkg::GroupW] = '0;
      end else begin
        addr[i6ap_pkg::AddrW-1-i*i6ap_pkg::GroupW -: i6ap_pkg::GroupW] =
          shifted[i6ap_pkg::AddrW-1-i*i6ap_pkg::GroupW -: i6ap_pkg::GroupW];
      end
    end
    if (ok_o) begin
      addr_high_o = addr[127:64];
      addr_low_o  = addr[63:0];
    end else begin
      addr_high_o = 64'd0;
      addr_low_o  = 64'd0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ipv6_text_address_parser.sv @@
// a nul character is registered in the input register, and its result in the result register
// throughput: one character per cycle; the only stall is a nul that meets an
//   unread result, set by the single result register
// reset (rst_ni, async, active low) returns the parser to the start of a string
//   and empties both the input and the result register
// top level of the ipv6 text address parser; depends on i6ap_pkg,
// i6ap_parse and i6ap_expand
`default_nettype none

module ipv6_text_address_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // character channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  character_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             valid_res_o,
  output logic [63:0]      address_high_o,
  output logic [63:0]      address_low_o
);

  // input register
  logic        in_valid_q;
  logic [7:0]  char_q;

  // result register
  logic        out_valid_q;
  logic        res_ok_q;
  logic [63:0] res_high_q;
  logic [63:0] res_low_q;

  logic           is_nul;
  logic           blocked;
  logic           consume;
  logic           res_load;
  i6ap_pkg::fin_t fin;
  logic [i6ap_pkg::NumGroups-1:0][i6ap_pkg::GroupW-1:0] groups;
  logic           ok;
  logic [63:0]    addr_high;
  logic [63:0]    addr_low;

  // a nul can only move on when the result register is free or being read
  assign is_nul     = (char_q == i6ap_pkg::ChNul);
  assign blocked    = is_nul && out_valid_q && out_stall_i;
  assign in_stall_o = in_valid_q && blocked;
  assign consume    = in_valid_q && !blocked;
  assign res_load   = consume && is_nul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= character_i;
    end
  end

  // state update for the character in the input register
  i6ap_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume),
    .char_i   (char_q),
    .fin_o    (fin),
    .groups_o (groups)
  );

  // result formed from the pre-nul state, captured as the nul is consumed
  i6ap_expand u_expand (
    .fin_i       (fin),
    .groups_i    (groups),
    .ok_o        (ok),
    .addr_high_o (addr_high),
    .addr_low_o  (addr_low)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_ok_q   <= ok;
      res_high_q <= addr_high;
      res_low_q  <= addr_low;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign valid_res_o    = res_ok_q;
  assign address_high_o = res_high_q;
  assign address_low_o  = res_low_q;

  // a failed parse always reports an all-zero address
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> address_high_o == 64'd0 && address_low_o == 64'd0)
    else $error("failed parse with nonzero address");

  // the character side stalls only for a nul that meets an unread result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && is_nul && out_valid_q && out_stall_i)
    else $error("character stall without a blocked nul");

  // a result that is read is not followed by another unless a nul was consumed
  a_res_from_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !(in_valid_q && is_nul) |=> !out_valid_q)
    else $error("result transaction without a nul");

  // a consumed non-nul character never produces a result
  a_no_res_non_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q && !(in_valid_q && is_nul) |=> !out_valid_q)
    else $error("result appeared without a nul");

endmodule

`default_nettype wire
